>>> rtl/core/ptw_pkg.sv
// Shared types, constants and helpers of the four-level page table walker.
package ptw_pkg;

  // Store geometry
  localparam int unsigned STORE_WORDS       = 4096;
  localparam int unsigned ENTRIES_PER_TABLE = 512;
  localparam int unsigned TABLES            = STORE_WORDS / ENTRIES_PER_TABLE;
  localparam int unsigned WORD_AW           = $clog2(STORE_WORDS);
  localparam int unsigned IDX_W             = $clog2(ENTRIES_PER_TABLE);

  // Field widths
  localparam int unsigned FUNC_W  = 2;
  localparam int unsigned EIDX_W  = 12;
  localparam int unsigned ENTRY_W = 64;
  localparam int unsigned FRAME_W = 40;
  localparam int unsigned VA_W    = 48;
  localparam int unsigned PA_W    = 52;
  localparam int unsigned FLAGS_W = 12;
  localparam int unsigned STAT_W  = 2;

  // Stream packing
  localparam int unsigned S_PAY_W   = EIDX_W + ENTRY_W + FRAME_W + VA_W;
  localparam int unsigned S_TDATA_W = ((S_PAY_W + 7) / 8) * 8;
  localparam int unsigned M_PAY_W   = STAT_W + PA_W + FLAGS_W + 1;
  localparam int unsigned M_TDATA_W = ((M_PAY_W + 7) / 8) * 8;

  // Walk levels
  localparam logic [1:0] LVL_PML4 = 2'd0;
  localparam logic [1:0] LVL_PDPT = 2'd1;
  localparam logic [1:0] LVL_PD   = 2'd2;
  localparam logic [1:0] LVL_PT   = 2'd3;

  // Entry bits
  localparam int unsigned BIT_PRESENT = 0;
  localparam int unsigned BIT_PS      = 7;

  typedef enum logic [FUNC_W-1:0] {
    FN_WRITE = 2'd0,
    FN_XLATE = 2'd1,
    FN_UNMAP = 2'd2
  } func_e;

  typedef enum logic [STAT_W-1:0] {
    ST_OK     = 2'd0,
    ST_ABSENT = 2'd1,
    ST_ALIGN  = 2'd2,
    ST_RANGE  = 2'd3
  } status_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_START,
    S_EVAL,
    S_DONE
  } state_e;

  typedef struct packed {
    logic [FUNC_W-1:0]  func;
    logic [EIDX_W-1:0]  entry_index;
    logic [ENTRY_W-1:0] entry_data;
    logic [FRAME_W-1:0] root_frame;
    logic [VA_W-1:0]    virt_addr;
  } item_t;

  typedef struct packed {
    logic [STAT_W-1:0]  status;
    logic [PA_W-1:0]    paddr;
    logic [FLAGS_W-1:0] page_flags;
    logic               is_huge;
  } result_t;

  // Table index of a virtual address at one walk level
  function automatic logic [IDX_W-1:0] va_index(logic [VA_W-1:0] va, logic [1:0] lvl);
    logic [IDX_W-1:0] idx;
    unique case (lvl)
      LVL_PML4: idx = va[47:39];
      LVL_PDPT: idx = va[38:30];
      LVL_PD:   idx = va[29:21];
      default:  idx = va[20:12];
    endcase
    return idx;
  endfunction

endpackage

>>> rtl/core/four_level_page_table_walker.sv
// Top level of the four-level page table walker with stream ports.
//
// The walker holds a 4096-word store of 64-bit entries standing in for the
// physical memory that carries the page tables; table frame F sits at words
// F*512 to F*512+511, so frames 0 to 7 are valid. Each input item either
// writes one store word, translates a 48-bit virtual address, or unmaps a
// 4 KB page, and gives exactly one result item. A translation walks PML4,
// PDPT, PD and PT, honours the page-size bit at PDPT (1 GB) and PD (2 MB),
// and returns the physical address with the full page offset, the low 12
// flag bits of the final entry and a huge-page marker. An unmap needs a
// 4 KB aligned address, walks all four levels on the present bit alone and
// clears the leaf entry. Store words must be written before a walk reads
// them. Items are taken one at a time: a new item is accepted only after the
// result of the last one has left the sequencer. A store write or an unused
// function passes through the start and done states only, while a walk also
// evaluates each level it reads, because every level waits for the registered
// read of the one store read port before the next table address is known; a
// misaligned unmap or a root frame outside the store reads no level. The result
// lands in an output register, so a new item is accepted while the previous result still waits downstream.
module four_level_page_table_walker (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  // Input items
  input  logic                            s_axis_tvalid_i,
  output logic                            s_axis_tready_o,
  // [11:0] entry_index, [75:12] entry_data, [115:76] root_frame,
  // [163:116] virt_addr, [167:164] zero
  input  logic [ptw_pkg::S_TDATA_W-1:0]   s_axis_tdata_i,
  // [1:0] func
  input  logic [ptw_pkg::FUNC_W-1:0]      s_axis_tuser_i,
  // Result items
  output logic                            m_axis_tvalid_o,
  input  logic                            m_axis_tready_i,
  // [1:0] status, [53:2] paddr, [65:54] page_flags, [66] is_huge,
  // [71:67] zero
  output logic [ptw_pkg::M_TDATA_W-1:0]   m_axis_tdata_o
);
  import ptw_pkg::*;

  item_t   item;
  result_t res;
  logic    res_valid, res_ready;
  logic    m_valid_q;
  result_t m_res_q;

  // Unpack the input item, lowest field first
  assign item.func        = s_axis_tuser_i;
  assign item.entry_index = s_axis_tdata_i[11:0];
  assign item.entry_data  = s_axis_tdata_i[75:12];
  assign item.root_frame  = s_axis_tdata_i[115:76];
  assign item.virt_addr   = s_axis_tdata_i[163:116];

  ptw_seq u_seq (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid_i),
    .in_ready_o (s_axis_tready_o),
    .item_i     (item),
    .res_valid_o(res_valid),
    .res_ready_i(res_ready),
    .res_o      (res)
  );

  // Output register: take a new result whenever the slot is empty or draining
  assign res_ready = !m_valid_q || m_axis_tready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_valid_q <= 1'b0;
    end else if (res_ready) begin
      m_valid_q <= res_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_ready && res_valid) begin
      m_res_q <= res;
    end
  end

  assign m_axis_tvalid_o = m_valid_q;
  assign m_axis_tdata_o  = {{(M_TDATA_W - M_PAY_W){1'b0}}, m_res_q.is_huge,
                            m_res_q.page_flags, m_res_q.paddr, m_res_q.status};

endmodule

>>> rtl/core/ptw_ram.sv
// Generic single-write, single-read memory with registered read data.
module ptw_ram #(
  parameter int unsigned DEPTH = 4096,
  parameter int unsigned WIDTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

>>> rtl/core/ptw_seq.sv
// Walk sequencer: one shared table-address unit stepped over the four levels.
module ptw_seq (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  ptw_pkg::item_t   item_i,
  output logic             res_valid_o,
  input  logic             res_ready_i,
  output ptw_pkg::result_t res_o
);
  import ptw_pkg::*;

  state_e              state_q, state_d;
  item_t               item_q;
  logic [1:0]          lvl_q, lvl_d;
  logic [WORD_AW-1:0]  addr_q, addr_d;
  result_t             res_q, res_d;

  // Store port
  logic                ram_we, ram_re;
  logic [WORD_AW-1:0]  ram_waddr, ram_raddr;
  logic [ENTRY_W-1:0]  ram_wdata, entry;

  // Shared table-address unit
  logic [FRAME_W-1:0]  au_frame;
  logic [1:0]          au_lvl;
  logic                au_ok;
  logic [WORD_AW-1:0]  au_addr;

  logic                present, leaf;
  logic [PA_W-1:0]     leaf_base, leaf_pa;

  ptw_ram #(
    .DEPTH(STORE_WORDS),
    .WIDTH(ENTRY_W)
  ) u_store (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .re_i   (ram_re),
    .raddr_i(ram_raddr),
    .rdata_o(entry)
  );

  // Frame from the root on the first step, from the returned entry afterwards
  always_comb begin
    if (state_q == S_START) begin
      au_frame = item_q.root_frame;
      au_lvl   = LVL_PML4;
    end else begin
      au_frame = entry[51:12];
      au_lvl   = lvl_q + 2'd1;
    end
    au_ok   = ({24'd0, au_frame} < 64'(TABLES));
    au_addr = WORD_AW'({au_frame, va_index(item_q.virt_addr, au_lvl)});
  end

  assign present   = entry[BIT_PRESENT];
  assign leaf      = (lvl_q == LVL_PT) ||
                     ((item_q.func == FN_XLATE) && entry[BIT_PS] &&
                      ((lvl_q == LVL_PDPT) || (lvl_q == LVL_PD)));
  assign leaf_base = {entry[51:12], 12'd0};

  // Join the page frame with the offset inside the page
  always_comb begin
    unique case (lvl_q)
      LVL_PDPT: leaf_pa = {leaf_base[51:30], item_q.virt_addr[29:0]};
      LVL_PD:   leaf_pa = {leaf_base[51:21], item_q.virt_addr[20:0]};
      default:  leaf_pa = {leaf_base[51:12], item_q.virt_addr[11:0]};
    endcase
  end

  always_comb begin
    state_d   = state_q;
    lvl_d     = lvl_q;
    addr_d    = addr_q;
    res_d     = res_q;
    ram_we    = 1'b0;
    ram_waddr = addr_q;
    ram_wdata = '0;
    ram_re    = 1'b0;
    ram_raddr = au_addr;

    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          state_d = S_START;
        end
      end
      S_START: begin
        res_d   = '0;
        state_d = S_DONE;
        case (item_q.func) inside
          FN_WRITE: begin
            if (32'(item_q.entry_index) < STORE_WORDS) begin
              ram_we    = 1'b1;
              ram_waddr = WORD_AW'(item_q.entry_index);
              ram_wdata = item_q.entry_data;
            end else begin
              res_d.status = ST_RANGE;
            end
          end
          FN_XLATE, FN_UNMAP: begin
            if ((item_q.func == FN_UNMAP) && (item_q.virt_addr[11:0] != 12'd0)) begin
              res_d.status = ST_ALIGN;
            end else if (!au_ok) begin
              res_d.status = ST_RANGE;
            end else begin
              ram_re  = 1'b1;
              addr_d  = au_addr;
              lvl_d   = LVL_PML4;
              state_d = S_EVAL;
            end
          end
          default: ;
        endcase
      end
      S_EVAL: begin
        if (!present) begin
          res_d.status = ST_ABSENT;
          state_d      = S_DONE;
        end else if (leaf) begin
          state_d = S_DONE;
          if (item_q.func == FN_XLATE) begin
            res_d.paddr      = leaf_pa;
            res_d.page_flags = entry[FLAGS_W-1:0];
            res_d.is_huge    = (lvl_q != LVL_PT);
          end else begin
            // Clear the leaf entry of an unmapped page
            ram_we = 1'b1;
          end
        end else if (!au_ok) begin
          res_d.status = ST_RANGE;
          state_d      = S_DONE;
        end else begin
          ram_re = 1'b1;
          addr_d = au_addr;
          lvl_d  = au_lvl;
        end
      end
      S_DONE: begin
        if (res_ready_i) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      item_q <= item_i;
    end
    lvl_q  <= lvl_d;
    addr_q <= addr_d;
    res_q  <= res_d;
  end

  assign in_ready_o  = (state_q == S_IDLE);
  assign res_valid_o = (state_q == S_DONE);
  assign res_o       = res_q;

  // A store write happens only while an item is being worked on
  a_we_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ram_we |-> ((state_q == S_START) || (state_q == S_EVAL)))
    else $error("store written outside a walk");

  // The last level always ends the walk
  a_pt_ends: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((state_q == S_EVAL) && (lvl_q == LVL_PT)) |=> (state_q == S_DONE))
    else $error("walk went past the last level");

  // An accepted item starts work on the next cycle
  a_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> (state_q == S_START))
    else $error("accepted item not started");

  // A finished result holds until it is taken
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((state_q == S_DONE) && !res_ready_i) |=> ((state_q == S_DONE) && $stable(res_q)))
    else $error("pending result lost");

endmodule

>>> sim/four_level_page_table_walker_tb.sv
// Self-checking stream testbench for the four-level page table walker.
module four_level_page_table_walker_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import ptw_pkg::*;

  // Function code with no operation behind it
  localparam logic [FUNC_W-1:0] FN_SPARE = 2'd3;
  localparam int unsigned PICK_POOL = 32;
  localparam int unsigned QUIET_LIMIT = 2000;
  localparam int unsigned STALL_CYCLES = 150;
  localparam int unsigned SETTLE_CYCLES = 20;

  logic                 clk_i = 1'b0;
  logic                 rst_ni = 1'b0;
  logic                 s_axis_tvalid_i = 1'b0;
  logic                 s_axis_tready_o;
  logic [S_TDATA_W-1:0] s_axis_tdata_i = '0;
  logic [FUNC_W-1:0]    s_axis_tuser_i = '0;
  logic                 m_axis_tvalid_o;
  logic                 m_axis_tready_i = 1'b0;
  logic [M_TDATA_W-1:0] m_axis_tdata_o;

  // Shadow of the table store and a mark for every word written so far
  logic [ENTRY_W-1:0]   shadow_store [STORE_WORDS];
  bit                   shadow_known [STORE_WORDS];
  result_t              pending_results [$];

  // Remembered walks, reused so that translations and unmaps meet again
  logic [FRAME_W-1:0]   pick_root [PICK_POOL];
  logic [VA_W-1:0]      pick_va   [PICK_POOL];

  int                   items_sent = 0;
  int                   results_seen = 0;
  int                   errors = 0;
  int                   quiet_cycles = 0;
  int                   hold_cycles = 0;
  int                   stall_asked = 0;
  int                   stall_given = 0;
  bit                   calm = 1'b0;

  four_level_page_table_walker u_top (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .s_axis_tuser_i  (s_axis_tuser_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // Walk the shadow tables for one item. With apply clear, nothing changes and the
  // walk stops at the first word never written (gap set, last_word names it). With
  // apply set, the item takes effect on the shadow store. last_lvl is the level of
  // the last word read, or -1 when no word was read.
  function automatic result_t predict_result(
      input logic [FUNC_W-1:0] fn, input logic [EIDX_W-1:0] widx,
      input logic [ENTRY_W-1:0] wdata, input logic [FRAME_W-1:0] root,
      input logic [VA_W-1:0] va, input bit apply,
      output bit gap, output logic [WORD_AW-1:0] last_word, output int last_lvl);
    result_t             r;
    logic [FRAME_W-1:0]  frame;
    logic [ENTRY_W-1:0]  e;
    logic [PA_W-1:0]     off;
    logic [IDX_W-1:0]    idx;
    logic [WORD_AW-1:0]  word;
    bit                  done;
    r = '0;
    r.status = ST_OK;
    gap = 1'b0;
    last_word = '0;
    last_lvl = -1;
    done = 1'b0;
    frame = root;
    if (fn == FN_WRITE) begin
      if (apply) begin
        shadow_store[widx] = wdata;
        shadow_known[widx] = 1'b1;
      end
    end else if (fn == FN_UNMAP && va[11:0] != '0) begin
      r.status = ST_ALIGN;
    end else if (fn == FN_XLATE || fn == FN_UNMAP) begin
      for (int lvl = 0; lvl < 4; lvl++) begin
        if (!done) begin
          if (frame >= TABLES) begin
            r.status = ST_RANGE;
            done = 1'b1;
          end else begin
            idx = IDX_W'(va >> (39 - 9 * lvl));
            word = WORD_AW'(frame * ENTRIES_PER_TABLE + idx);
            last_word = word;
            last_lvl = lvl;
            if (!shadow_known[word]) begin
              gap = 1'b1;
              done = 1'b1;
            end else begin
              e = shadow_store[word];
              if (!e[BIT_PRESENT]) begin
                r.status = ST_ABSENT;
                done = 1'b1;
              end else if (fn == FN_UNMAP) begin
                // Unmap follows the present bit alone and clears the leaf
                if (lvl == 3) begin
                  if (apply) shadow_store[word] = '0;
                  done = 1'b1;
                end
              end else if (lvl == 3 || ((lvl == 1 || lvl == 2) && e[BIT_PS])) begin
                off = (52'd1 << (39 - 9 * lvl)) - 52'd1;
                r.paddr = (e[PA_W-1:0] & ~off) | ({4'b0, va} & off);
                r.page_flags = e[FLAGS_W-1:0];
                r.is_huge = (lvl != 3);
                done = 1'b1;
              end
              frame = e[51:12];
            end
          end
        end
      end
    end
    return r;
  endfunction

  // Random table entry for a given level: mostly a pointer to a table inside the
  // store, sometimes absent, a huge page, or a pointer beyond the store
  function automatic logic [ENTRY_W-1:0] make_entry(input int lvl);
    logic [ENTRY_W-1:0] e;
    int                 pick;
    bit                 leaf;
    e = {$urandom, $urandom};
    pick = $urandom_range(99);
    if (pick < 8) begin
      e[BIT_PRESENT] = 1'b0;
    end else begin
      e[BIT_PRESENT] = 1'b1;
      leaf = (lvl == LVL_PT) || ((lvl == LVL_PDPT || lvl == LVL_PD) && pick < 28);
      if (leaf && lvl != LVL_PT) e[BIT_PS] = 1'b1;
      if (!leaf) begin
        // Page size bit stays random at the top level, where it means nothing
        if (lvl != LVL_PML4) e[BIT_PS] = 1'b0;
        if (pick < 94) e[51:12] = 40'($urandom_range(TABLES - 1));
        else if (e[51:15] == '0) e[51] = 1'b1;
      end
    end
    return e;
  endfunction

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    $display("%0t result %0d: %s got %0h want %0h", $realtime, results_seen, what,
             got, want);
    errors++;
  endtask

  // Offer one item, hold it until accepted, then record what it must produce
  task automatic send_item(input logic [FUNC_W-1:0] fn, input logic [EIDX_W-1:0] widx,
                           input logic [ENTRY_W-1:0] wdata, input logic [FRAME_W-1:0] root,
                           input logic [VA_W-1:0] va);
    result_t            r;
    bit                 gap;
    logic [WORD_AW-1:0] word;
    int                 lvl;
    if (!calm) begin
      while ($urandom_range(99) < 21) begin
        s_axis_tvalid_i <= 1'b0;
        @(posedge clk_i);
      end
    end
    s_axis_tvalid_i <= 1'b1;
    s_axis_tuser_i  <= fn;
    s_axis_tdata_i  <= {4'b0, va, root, wdata, widx};
    @(posedge clk_i);
    while (!s_axis_tready_o) @(posedge clk_i);
    r = predict_result(fn, widx, wdata, root, va, 1'b1, gap, word, lvl);
    pending_results.push_back(r);
    items_sent++;
  endtask

  // Send a walk, first writing every table word it would read that holds nothing yet
  task automatic walk_item(input logic [FUNC_W-1:0] fn, input logic [FRAME_W-1:0] root,
                           input logic [VA_W-1:0] va);
    result_t            r;
    bit                 gap;
    logic [WORD_AW-1:0] word;
    int                 lvl;
    r = predict_result(fn, '0, '0, root, va, 1'b0, gap, word, lvl);
    while (gap) begin
      send_item(FN_WRITE, word, make_entry(lvl), 40'({$urandom, $urandom}),
                48'({$urandom, $urandom}));
      r = predict_result(fn, '0, '0, root, va, 1'b0, gap, word, lvl);
    end
    send_item(fn, 12'($urandom), {$urandom, $urandom}, root, va);
  endtask

  // Mostly well-formed walks over a shared pool of addresses, with some noise
  task automatic run_mix(input int target);
    result_t            r;
    bit                 gap;
    logic [WORD_AW-1:0] word;
    int                 lvl;
    int                 sel;
    int                 slot;
    bit                 reuse;
    logic [FRAME_W-1:0] root;
    logic [VA_W-1:0]    va;
    while (items_sent < target) begin
      sel = $urandom_range(99);
      slot = $urandom_range(PICK_POOL - 1);
      reuse = $urandom_range(1);
      root = reuse ? pick_root[slot] : 40'($urandom_range(TABLES - 1));
      va = reuse ? pick_va[slot] : 48'({$urandom, $urandom});
      if (sel < 40) begin
        walk_item(FN_XLATE, root, va);
      end else if (sel < 58) begin
        walk_item(FN_UNMAP, root, {va[47:12], 12'h000});
      end else if (sel < 63) begin
        va[11:0] = 12'($urandom_range(1, 4095));
        walk_item(FN_UNMAP, root, va);
      end else if (sel < 78) begin
        // Rewrite the last entry this walk reaches, then translate again
        r = predict_result(FN_XLATE, '0, '0, root, va, 1'b0, gap, word, lvl);
        if (!gap && lvl >= 0) begin
          send_item(FN_WRITE, word, make_entry(lvl), 40'({$urandom, $urandom}),
                    48'({$urandom, $urandom}));
        end
        walk_item(FN_XLATE, root, va);
      end else if (sel < 83) begin
        send_item(FN_WRITE, 12'($urandom), {$urandom, $urandom},
                  40'({$urandom, $urandom}), 48'({$urandom, $urandom}));
      end else if (sel < 88) begin
        root = 40'({$urandom, $urandom});
        if (root < TABLES) root[39] = 1'b1;
        send_item(sel[0] ? FN_XLATE : FN_UNMAP, 12'($urandom), {$urandom, $urandom},
                  root, va);
      end else if (sel < 91) begin
        send_item(FN_SPARE, 12'($urandom), {$urandom, $urandom},
                  40'({$urandom, $urandom}), 48'({$urandom, $urandom}));
      end else begin
        walk_item(FN_XLATE, pick_root[slot], pick_va[slot]);
      end
      if (!reuse) begin
        pick_root[slot] = root;
        pick_va[slot] = va;
      end
    end
  endtask

  // Hand-built tables: 1 GB, 2 MB and 4 KB pages, absent entries, frames outside
  // the store, misaligned and repeated unmaps, the spare function code
  task automatic test_directed_walks();
    localparam logic [VA_W-1:0] VA_1G = 48'h0000_3FFF_FFFF;
    localparam logic [VA_W-1:0] VA_2M = 48'h0000_401F_FFFF;
    localparam logic [VA_W-1:0] VA_4K = 48'h0000_4020_0FFF;
    localparam logic [VA_W-1:0] VA_4K_GONE = 48'h0000_4020_1000;
    send_item(FN_WRITE, 12'd0, '1, '0, '0);
    walk_item(FN_XLATE, 40'd0, 48'h0);
    send_item(FN_XLATE, '0, '0, 40'(TABLES), VA_4K);
    send_item(FN_UNMAP, '0, '0, '1, '0);
    // Page size bit set at the top level, where it is ignored
    send_item(FN_WRITE, 12'd0, 64'hFFF0_0000_0000_1081, '0, '0);
    send_item(FN_WRITE, 12'd512, 64'h000F_FFFF_C000_0F83, '0, '0);
    walk_item(FN_XLATE, 40'd0, VA_1G);
    send_item(FN_WRITE, 12'd513, 64'h0000_0000_0000_2003, '0, '0);
    send_item(FN_WRITE, 12'd1024, 64'h0000_0000_2AE0_0081, '0, '0);
    walk_item(FN_XLATE, 40'd0, VA_2M);
    send_item(FN_WRITE, 12'd1025, 64'h0000_0000_0000_3003, '0, '0);
    // Page size bit in a last-level entry is a cache attribute only
    send_item(FN_WRITE, 12'd1536, '1, '0, '0);
    send_item(FN_WRITE, 12'd1537, '0, '0, '0);
    walk_item(FN_XLATE, 40'd0, VA_4K);
    walk_item(FN_XLATE, 40'd0, VA_4K_GONE);
    walk_item(FN_UNMAP, 40'd0, VA_4K);
    walk_item(FN_UNMAP, 40'd0, {VA_4K[47:12], 12'h000});
    walk_item(FN_XLATE, 40'd0, VA_4K);
    walk_item(FN_UNMAP, 40'd0, {VA_4K[47:12], 12'h000});
    // Unmap walks through a 1 GB entry as if it pointed at a table
    walk_item(FN_UNMAP, 40'd0, {VA_1G[47:12], 12'h000});
    send_item(FN_SPARE, '1, '1, '1, '1);
    send_item(FN_WRITE, '1, '0, '0, '0);
    walk_item(FN_XLATE, 40'(TABLES - 1), '1);
    foreach (pick_va[i]) begin
      pick_root[i] = 40'($urandom_range(TABLES - 1));
      pick_va[i] = 48'({$urandom, $urandom});
    end
  endtask

  task automatic test_random_mix();
    run_mix(items_sent + 600);
  endtask

  // Back-to-back items and results with no gaps on either side
  task automatic test_calm_stream();
    calm = 1'b1;
    run_mix(items_sent + 200);
    calm = 1'b0;
  endtask

  // Hold the result side off while items keep coming, so the input backs up
  task automatic test_output_stall();
    stall_asked++;
    run_mix(items_sent + 30);
  endtask

  // Pause the sender until every result is back, then carry on
  task automatic test_drain_pause();
    s_axis_tvalid_i <= 1'b0;
    do @(posedge clk_i); while (pending_results.size() != 0);
    run_mix(items_sent + 150);
  endtask

  // Result side: random stalls, a calm phase and a long hold-off on request
  always @(posedge clk_i) begin
    if (stall_given != stall_asked) begin
      m_axis_tready_i <= 1'b0;
      hold_cycles <= int'(STALL_CYCLES);
      stall_given <= stall_asked;
    end else if (hold_cycles > 0) begin
      m_axis_tready_i <= 1'b0;
      hold_cycles <= hold_cycles - 1;
    end else if (calm) begin
      m_axis_tready_i <= 1'b1;
    end else begin
      m_axis_tready_i <= ($urandom_range(99) >= 21);
    end
  end

  // Compare every accepted result with the oldest one pending
  always @(posedge clk_i) begin : check_result
    result_t want;
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i) begin
      if (pending_results.size() == 0) begin
        report_mismatch("result with nothing pending", 64'(m_axis_tdata_o), '0);
      end else begin
        want = pending_results.pop_front();
        if (m_axis_tdata_o[1:0] !== want.status)
          report_mismatch("status", 64'(m_axis_tdata_o[1:0]), 64'(want.status));
        if (m_axis_tdata_o[53:2] !== want.paddr)
          report_mismatch("paddr", 64'(m_axis_tdata_o[53:2]), 64'(want.paddr));
        if (m_axis_tdata_o[65:54] !== want.page_flags)
          report_mismatch("page_flags", 64'(m_axis_tdata_o[65:54]),
                          64'(want.page_flags));
        if (m_axis_tdata_o[66] !== want.is_huge)
          report_mismatch("is_huge", 64'(m_axis_tdata_o[66]), 64'(want.is_huge));
      end
      results_seen++;
    end
  end

  // Give up when neither side has moved an item for too long
  always @(posedge clk_i) begin
    if ((s_axis_tvalid_i && s_axis_tready_o) || (m_axis_tvalid_o && m_axis_tready_i))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles == QUIET_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  initial begin
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed_walks();
    test_random_mix();
    test_calm_stream();
    test_output_stall();
    test_drain_pause();
    // Drop valid, wait for the last results, then allow a few walk times more
    s_axis_tvalid_i <= 1'b0;
    do @(posedge clk_i); while (pending_results.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (errors == 0 && pending_results.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

>>> four_level_page_table_walker.f
rtl/core/ptw_pkg.sv
rtl/core/ptw_ram.sv
rtl/core/ptw_seq.sv
rtl/core/four_level_page_table_walker.sv
sim/four_level_page_table_walker_tb.sv
